@@ design/bra_pkg.sv @@
// Shared constants, opcodes and inter-stage types for the bitmap run allocator.
// No dependencies; every other design file but bra_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bra_pkg;

  // Map geometry
  localparam int MapBytes = 512;
  localparam int MapBits  = MapBytes * 8;
  localparam int WordW    = 64;
  localparam int WordLg   = $clog2(WordW);
  localparam int Words    = (MapBits + WordW - 1) / WordW;
  localparam int WordAw   = (Words > 1) ? $clog2(Words) : 1;

  // Field widths
  localparam int OpW  = 2;
  localparam int IdxW = 12;
  localparam int CntW = 13;

  // Stream widths, padded to whole bytes
  localparam int InW  = ((IdxW + 1 + CntW + 7) / 8) * 8;
  localparam int OutW = ((2 + IdxW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  // Per-word scan summary, registered after the RAM read
  typedef struct packed {
    logic              vld;
    logic [WordAw-1:0] addr;
    logic [WordW-1:0]  pz;     // bits below the lowest set bit
    logic [WordW-1:0]  inrun;  // run of len zeros ends here, inside the word
    logic [WordLg:0]   topz;   // free bits at the top end of the word
  } word_info_t;

  typedef struct packed {
    logic            hit;
    logic            done;
    logic [IdxW-1:0] start;
  } match_t;

endpackage

`default_nettype wire

@@ design/bitmap_run_allocator.sv @@
// First-fit bitmap allocator: control, word-valid bits and result register.
// Depends on bra_pkg, bra_ram, bra_word_eval and bra_run_track.
//
// Use:
//   Requests enter on the s_axis channel, one per transfer; the opcode rides
//   on tuser (clear map, read mark, write mark, scan). Every request yields
//   exactly one transfer on m_axis: the read mark, or the scan's found flag
//   and lowest start of a free run of the requested length.
//   The 4096 marks live in a 64 x 64-bit RAM with a registered read port.
//   A valid bit per word, cleared at once, stands in for a zeroed word, so
//   a clear takes effect at once and no clearing pass runs after reset.
//   A clear goes through state FIN, a read or write through ACC
//   (read-modify-write of one word) and then FIN, before the result
//   is registered. One request is worked at a time; a new one is taken
//   the cycle after the result is registered.
//   A scan streams the words through a two-stage evaluation pipeline, one
//   word per cycle set by the single RAM read port, and ends at the first
//   word that completes a run or at the last word. Zero or over-long lengths
//   finish at once as not found.
//   Reset leaves the map all free and both channels idle.
//   The result sits in an output register; while the receiver stalls the
//   block still accepts the next request and holds its result until the
//   register frees up.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_run_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [bra_pkg::InW-1:0]   s_axis_tdata,  // index[11:0], value, count[12:0]
  input  logic [bra_pkg::OpW-1:0]   s_axis_tuser,  // op
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bra_pkg::OutW-1:0]  m_axis_tdata   // bit_value, found, start_index[11:0]
);
  import bra_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_SCAN,
    ST_FIN
  } state_e;

  // Request decode
  logic [IdxW-1:0]   in_idx;
  logic              in_val;
  logic [CntW-1:0]   in_cnt;
  op_e               in_op;
  logic [WordAw-1:0] in_word;

  assign in_idx  = s_axis_tdata[IdxW-1:0];
  assign in_val  = s_axis_tdata[IdxW];
  assign in_cnt  = s_axis_tdata[IdxW+1 +: CntW];
  assign in_op   = op_e'(s_axis_tuser);
  assign in_word = WordAw'(in_idx >> WordLg);

  state_e            state_d, state_q;
  op_e               op_d, op_q;
  logic [IdxW-1:0]   idx_d, idx_q;
  logic              val_d, val_q;
  logic [CntW-1:0]   len_d, len_q;
  logic [Words-1:0]  wvld_d, wvld_q;     // word holds written data
  logic [WordAw:0]   iss_d, iss_q;       // scan read pointer
  logic              rd_v_d, rd_v_q;     // scan read data arrives
  logic [WordAw-1:0] rd_addr_d, rd_addr_q;
  logic              rd_wv_d, rd_wv_q;
  logic              res_bit_d, res_bit_q;
  logic              res_found_d, res_found_q;
  logic [IdxW-1:0]   res_start_d, res_start_q;
  logic              o_vld_d, o_vld_q;
  logic              o_bit_d, o_bit_q;
  logic              o_found_d, o_found_q;
  logic [IdxW-1:0]   o_start_d, o_start_q;

  // RAM port
  logic              ram_we;
  logic              ram_re;
  logic [WordAw-1:0] ram_raddr;
  logic [WordW-1:0]  ram_wdata;
  logic [WordW-1:0]  ram_rdata;

  logic [WordW-1:0]  acc_word;
  logic              idx_in_map;
  logic              scan_clr;
  word_info_t        info;
  match_t            match;

  assign acc_word   = rd_wv_q ? ram_rdata : '0;
  assign idx_in_map = int'(idx_q) < MapBits;

  bra_ram #(
    .Width (WordW),
    .Depth (Words)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bra_word_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (rd_v_q),
    .addr_i   (rd_addr_q),
    .wvalid_i (rd_wv_q),
    .rdata_i  (ram_rdata),
    .len_i    (len_q),
    .info_o   (info)
  );

  bra_run_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (scan_clr),
    .len_i   (len_q),
    .info_i  (info),
    .match_o (match)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    val_d       = val_q;
    len_d       = len_q;
    wvld_d      = wvld_q;
    iss_d       = iss_q;
    rd_v_d      = 1'b0;
    rd_addr_d   = rd_addr_q;
    rd_wv_d     = rd_wv_q;
    res_bit_d   = res_bit_q;
    res_found_d = res_found_q;
    res_start_d = res_start_q;
    o_vld_d     = o_vld_q & ~m_axis_tready;
    o_bit_d     = o_bit_q;
    o_found_d   = o_found_q;
    o_start_d   = o_start_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = in_word;
    scan_clr    = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    ram_wdata = acc_word;
    ram_wdata[idx_q[WordLg-1:0]] = val_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d        = in_op;
          idx_d       = in_idx;
          val_d       = in_val;
          len_d       = in_cnt;
          res_bit_d   = 1'b0;
          res_found_d = 1'b0;
          res_start_d = '0;
          case (in_op)
            OP_CLEAR: begin
              wvld_d  = '0;
              state_d = ST_FIN;
            end
            OP_READ, OP_WRITE: begin
              ram_re    = 1'b1;
              ram_raddr = in_word;
              rd_addr_d = in_word;
              rd_wv_d   = wvld_q[in_word];
              state_d   = ST_ACC;
            end
            OP_SCAN: begin
              if (in_cnt == '0 || int'(in_cnt) > MapBits) begin
                state_d = ST_FIN;
              end else begin
                iss_d    = '0;
                scan_clr = 1'b1;
                state_d  = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_ACC: begin
        case (op_q)
          OP_READ: begin
            res_bit_d = idx_in_map & acc_word[idx_q[WordLg-1:0]];
          end
          OP_WRITE: begin
            if (idx_in_map) begin
              ram_we            = 1'b1;
              wvld_d[rd_addr_q] = 1'b1;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_FIN;
      end
      ST_SCAN: begin
        if (int'(iss_q) < Words) begin
          ram_re    = 1'b1;
          ram_raddr = iss_q[WordAw-1:0];
          iss_d     = iss_q + 1'b1;
          rd_v_d    = 1'b1;
          rd_addr_d = iss_q[WordAw-1:0];
          rd_wv_d   = wvld_q[iss_q[WordAw-1:0]];
        end
        if (match.done) begin
          res_found_d = match.hit;
          res_start_d = match.hit ? match.start : '0;
          state_d     = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!o_vld_q || m_axis_tready) begin
          o_vld_d   = 1'b1;
          o_bit_d   = res_bit_q;
          o_found_d = res_found_q;
          o_start_d = res_start_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_CLEAR;
      idx_q       <= '0;
      val_q       <= 1'b0;
      len_q       <= '0;
      wvld_q      <= '0;
      iss_q       <= '0;
      rd_v_q      <= 1'b0;
      rd_addr_q   <= '0;
      rd_wv_q     <= 1'b0;
      res_bit_q   <= 1'b0;
      res_found_q <= 1'b0;
      res_start_q <= '0;
      o_vld_q     <= 1'b0;
      o_bit_q     <= 1'b0;
      o_found_q   <= 1'b0;
      o_start_q   <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      idx_q       <= idx_d;
      val_q       <= val_d;
      len_q       <= len_d;
      wvld_q      <= wvld_d;
      iss_q       <= iss_d;
      rd_v_q      <= rd_v_d;
      rd_addr_q   <= rd_addr_d;
      rd_wv_q     <= rd_wv_d;
      res_bit_q   <= res_bit_d;
      res_found_q <= res_found_d;
      res_start_q <= res_start_d;
      o_vld_q     <= o_vld_d;
      o_bit_q     <= o_bit_d;
      o_found_q   <= o_found_d;
      o_start_q   <= o_start_d;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = {{(OutW - IdxW - 2){1'b0}}, o_start_q, o_found_q, o_bit_q};

endmodule

`default_nettype wire

@@ design/bra_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bra_ram #(
  parameter  int Width = 8,
  parameter  int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/bra_word_eval.sv @@
// Scan stage 1: summarizes one map word for run tracking, output registered.
// Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bra_word_eval (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [bra_pkg::WordAw-1:0] addr_i,
  input  logic                       wvalid_i,
  input  logic [bra_pkg::WordW-1:0]  rdata_i,
  input  logic [bra_pkg::CntW-1:0]   len_i,
  output bra_pkg::word_info_t        info_o
);
  import bra_pkg::*;

  word_info_t info_d, info_q;

  always_comb begin
    logic [WordW-1:0]          word;
    logic [WordW-1:0]          rev;
    logic [WordW-1:0]          pzr;
    logic [WordLg:0][WordW-1:0] pw;
    logic [WordLg:0]           off;
    logic [WordW-1:0]          inrun;

    word = wvalid_i ? rdata_i : '0;
    // bits past the end of the map count as taken
    for (int b = 0; b < WordW; b++) begin
      if ((int'(addr_i) * WordW + b) >= MapBits) begin
        word[b] = 1'b1;
      end
    end
    for (int b = 0; b < WordW; b++) begin
      rev[b] = word[WordW-1-b];
    end
    pzr = (rev - WordW'(1)) & ~rev;

    // pw[i][q]: bits q-2^i+1 .. q all free
    pw[0] = ~word;
    for (int i = 1; i <= WordLg; i++) begin
      pw[i] = pw[i-1] & (pw[i-1] << (1 << (i-1)));
    end

    inrun = '1;
    for (int i = 0; i <= WordLg; i++) begin
      off = (len_i[WordLg:0] >> (i + 1)) << (i + 1);
      if (len_i[i]) begin
        inrun = inrun & (pw[i] << off);
      end
    end
    if (len_i > CntW'(WordW)) begin
      inrun = '0;
    end

    info_d.vld   = vld_i;
    info_d.addr  = addr_i;
    info_d.pz    = (word - WordW'(1)) & ~word;
    info_d.inrun = inrun;
    info_d.topz  = (WordLg+1)'($countones(pzr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_q <= '0;
    end else begin
      info_q <= info_d;
    end
  end

  assign info_o = info_q;

endmodule

`default_nettype wire

@@ design/bra_run_track.sv @@
// Scan stage 2: carries the free run across words and finds the first fit.
// Depends on bra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bra_run_track (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic [bra_pkg::CntW-1:0] len_i,
  input  bra_pkg::word_info_t      info_i,
  output bra_pkg::match_t          match_o
);
  import bra_pkg::*;

  logic [CntW-1:0] run_d, run_q;

  always_comb begin
    logic [CntW-1:0]   need;
    logic [WordW-1:0]  thr;
    logic [WordW-1:0]  cand;
    logic [WordLg-1:0] pos;
    logic [CntW:0]     endp;
    logic [CntW:0]     start_full;

    need = len_i - run_q;
    for (int p = 0; p < WordW; p++) begin
      thr[p] = ((p + 1) >= int'(need));
    end
    cand = (info_i.pz & thr) | info_i.inrun;

    pos = '0;
    for (int p = WordW - 1; p >= 0; p--) begin
      if (cand[p]) begin
        pos = WordLg'(p);
      end
    end
    endp       = (CntW+1)'({info_i.addr, pos}) + (CntW+1)'(1);
    start_full = endp - (CntW+1)'(len_i);

    match_o.hit   = info_i.vld && (|cand);
    match_o.done  = info_i.vld && ((|cand) || (info_i.addr == WordAw'(Words - 1)));
    match_o.start = start_full[IdxW-1:0];

    run_d = run_q;
    if (clr_i) begin
      run_d = '0;
    end else if (info_i.vld) begin
      if (info_i.topz[WordLg]) begin
        run_d = run_q + CntW'(WordW);
      end else begin
        run_d = CntW'(info_i.topz);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bra_checker.sv @@
// Port-level checks for the bitmap run allocator, bound to the top level.
// Depends on bra_pkg and bitmap_run_allocator.
`timescale 1ns / 1ps
`default_nettype none

module bra_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [bra_pkg::OutW-1:0] m_axis_tdata
);
  import bra_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // start index only reported with found
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[IdxW+1:2] == '0)
    else $error("start index without found");

  // read mark and found never both set
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("bit value and found both set");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
